// ===== hw/rtl/fltpe_pkg.sv =====
package fltpe_pkg;

    // default store size in table pages
    localparam int TABLE_PAGES_DEF = 64;

    // table geometry
    localparam int ENTRY_W  = 64;
    localparam int IDX_W    = 9;
    localparam int PADDR_W  = 52;
    localparam int VADDR_W  = 48;
    localparam int PAGE_SH  = 12;
    localparam int FRAME_W  = PADDR_W - PAGE_SH;
    localparam int PROT_W   = 6;

    // request codes
    localparam logic [1:0] OP_MAP    = 2'd0;
    localparam logic [1:0] OP_UNMAP  = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // entry bit positions
    localparam int B_PRESENT = 0;
    localparam int B_WRITE   = 1;
    localparam int B_USER    = 2;
    localparam int B_PCD     = 4;
    localparam int B_WC      = 7;
    localparam int B_OWNER   = 9;
    localparam int B_NX      = 63;

    // flags of an entry that points to a lower table
    localparam logic [ENTRY_W-1:0] DIR_FLAGS =
        (ENTRY_W'(1) << B_WRITE) | (ENTRY_W'(1) << B_USER) | (ENTRY_W'(1) << B_PRESENT);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [VADDR_W-1:0] virt_addr;
        logic [PADDR_W-1:0] phys_addr;
        logic [PROT_W-1:0]  prot_bits;
        logic               owner_flag;
    } req_t;

    typedef struct packed {
        logic               status;
        logic               mapped;
        logic [PADDR_W-1:0] frame_base;
        logic [PROT_W-1:0]  prot_out;
        logic               owner_out;
    } resp_t;

    // leaf entry from frame address, protection and owner flag
    function automatic logic [ENTRY_W-1:0] encode_leaf(
        input logic [PADDR_W-1:0] phys,
        input logic [PROT_W-1:0]  prot,
        input logic               own
    );
        logic [ENTRY_W-1:0] e;
        e = {{(ENTRY_W-PADDR_W){1'b0}}, phys[PADDR_W-1:PAGE_SH], {PAGE_SH{1'b0}}};
        e[B_PRESENT] = prot[0];
        e[B_WRITE]   = prot[1];
        e[B_NX]      = ~prot[2];
        e[B_USER]    = prot[3];
        e[B_PCD]     = prot[4];
        e[B_WC]      = prot[5];
        e[B_OWNER]   = own;
        return e;
    endfunction

    // protection of a leaf entry in request encoding
    function automatic logic [PROT_W-1:0] decode_prot(input logic [ENTRY_W-1:0] e);
        return {e[B_WC], e[B_PCD], e[B_USER], ~e[B_NX], e[B_WRITE], e[B_PRESENT]};
    endfunction

endpackage

// ===== hw/rtl/fltpe_ram.sv =====
module fltpe_ram #(
    parameter int ADDR_W = 15,
    parameter int DEPTH  = 32768
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             addr,
    input  logic [fltpe_pkg::ENTRY_W-1:0] wr_data,
    output logic [fltpe_pkg::ENTRY_W-1:0] rd_data
);

    logic [fltpe_pkg::ENTRY_W-1:0] store_mem [DEPTH];
    logic [fltpe_pkg::ENTRY_W-1:0] rd_data_reg;

    // single port, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[addr] <= wr_data;
        end
        rd_data_reg <= store_mem[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/fltpe_walker.sv =====
module fltpe_walker #(
    parameter int TABLE_PAGES = fltpe_pkg::TABLE_PAGES_DEF,
    parameter int PG_W        = $clog2(TABLE_PAGES),
    parameter int ADDR_W      = PG_W + fltpe_pkg::IDX_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request side
    input  logic                          req_valid,
    output logic                          req_ready,
    input  fltpe_pkg::req_t               req_data,
    // result side
    output logic                          res_valid,
    input  logic                          res_ready,
    output fltpe_pkg::resp_t              res_data,
    // page store port
    output logic                          mem_we,
    output logic [ADDR_W-1:0]             mem_addr,
    output logic [fltpe_pkg::ENTRY_W-1:0] mem_wdata,
    input  logic [fltpe_pkg::ENTRY_W-1:0] mem_rdata
);

    localparam int CNT_W = $clog2(TABLE_PAGES + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_PAGES * 512 - 1);
    localparam logic [CNT_W-1:0]  PAGES_CNT = CNT_W'(TABLE_PAGES);
    localparam logic [fltpe_pkg::FRAME_W-1:0] PAGES_FRM =
        fltpe_pkg::FRAME_W'(TABLE_PAGES);

    fltpe_pkg::state_t state_reg, state_next;
    fltpe_pkg::req_t   req_reg, req_next;
    fltpe_pkg::resp_t  res_reg, res_next;
    logic [1:0]        lvl_reg, lvl_next;
    logic [PG_W-1:0]   pg_reg, pg_next;
    logic [CNT_W-1:0]  nfp_reg, nfp_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;

    logic [fltpe_pkg::IDX_W-1:0]   cur_idx;
    logic [fltpe_pkg::FRAME_W-1:0] ent_frame;
    logic                          child_ok;

    // table index of the current level
    always_comb begin
        case (lvl_reg)
            2'd0:    cur_idx = req_reg.virt_addr[47:39];
            2'd1:    cur_idx = req_reg.virt_addr[38:30];
            2'd2:    cur_idx = req_reg.virt_addr[29:21];
            default: cur_idx = req_reg.virt_addr[20:12];
        endcase
    end

    // does the fetched entry point to a table page in the store
    assign ent_frame = mem_rdata[fltpe_pkg::PADDR_W-1:fltpe_pkg::PAGE_SH];
    assign child_ok  = mem_rdata[fltpe_pkg::B_PRESENT] && (ent_frame != '0)
                       && (ent_frame < PAGES_FRM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fltpe_pkg::ST_CLEAR;
            nfp_reg   <= CNT_W'(1);
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            nfp_reg   <= nfp_next;
            clr_reg   <= clr_next;
        end
    end

    // walk context, no reset needed
    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        res_reg <= res_next;
        lvl_reg <= lvl_next;
        pg_reg  <= pg_next;
    end

    // walk sequencer
    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        lvl_next   = lvl_reg;
        pg_next    = pg_reg;
        nfp_next   = nfp_reg;
        clr_next   = clr_reg;
        mem_we     = 1'b0;
        mem_addr   = {pg_reg, cur_idx};
        mem_wdata  = '0;
        req_ready  = 1'b0;
        res_valid  = 1'b0;

        case (state_reg)
            fltpe_pkg::ST_CLEAR: begin
                // zero the whole store after reset
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == LAST_ADDR) begin
                    state_next = fltpe_pkg::ST_IDLE;
                end
            end

            fltpe_pkg::ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    req_next = req_data;
                    res_next = '0;
                    lvl_next = 2'd0;
                    pg_next  = '0;
                    if (req_data.op == fltpe_pkg::OP_MAP
                        || req_data.op == fltpe_pkg::OP_UNMAP
                        || req_data.op == fltpe_pkg::OP_LOOKUP) begin
                        state_next = fltpe_pkg::ST_READ;
                    end else begin
                        state_next = fltpe_pkg::ST_DONE;
                    end
                end
            end

            fltpe_pkg::ST_READ: begin
                if (lvl_reg == 2'd3 && req_reg.op == fltpe_pkg::OP_MAP) begin
                    // write the leaf
                    mem_we     = 1'b1;
                    mem_wdata  = fltpe_pkg::encode_leaf(req_reg.phys_addr,
                                                        req_reg.prot_bits,
                                                        req_reg.owner_flag);
                    state_next = fltpe_pkg::ST_DONE;
                end else if (lvl_reg == 2'd3 && req_reg.op == fltpe_pkg::OP_UNMAP) begin
                    // clear the leaf
                    mem_we     = 1'b1;
                    state_next = fltpe_pkg::ST_DONE;
                end else begin
                    state_next = fltpe_pkg::ST_CHECK;
                end
            end

            fltpe_pkg::ST_CHECK: begin
                if (lvl_reg == 2'd3) begin
                    // lookup result from the leaf
                    res_next.mapped     = mem_rdata[fltpe_pkg::B_PRESENT];
                    res_next.frame_base = {ent_frame, {fltpe_pkg::PAGE_SH{1'b0}}};
                    res_next.prot_out   = fltpe_pkg::decode_prot(mem_rdata);
                    res_next.owner_out  = mem_rdata[fltpe_pkg::B_OWNER];
                    state_next          = fltpe_pkg::ST_DONE;
                end else if (child_ok) begin
                    pg_next    = ent_frame[PG_W-1:0];
                    lvl_next   = lvl_reg + 2'd1;
                    state_next = fltpe_pkg::ST_READ;
                end else if (req_reg.op == fltpe_pkg::OP_MAP) begin
                    if (nfp_reg >= PAGES_CNT) begin
                        res_next.status = 1'b1;
                        state_next      = fltpe_pkg::ST_DONE;
                    end else begin
                        // link the next free page into this level
                        mem_we     = 1'b1;
                        mem_wdata  = (fltpe_pkg::ENTRY_W'(nfp_reg) << fltpe_pkg::PAGE_SH)
                                     | fltpe_pkg::DIR_FLAGS;
                        pg_next    = nfp_reg[PG_W-1:0];
                        nfp_next   = nfp_reg + CNT_W'(1);
                        lvl_next   = lvl_reg + 2'd1;
                        state_next = fltpe_pkg::ST_READ;
                    end
                end else begin
                    // missing level on unmap or lookup
                    state_next = fltpe_pkg::ST_DONE;
                end
            end

            fltpe_pkg::ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = fltpe_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = fltpe_pkg::ST_IDLE;
            end
        endcase
    end

    assign res_data = res_reg;

endmodule

// ===== hw/rtl/four_level_page_table_engine_unit.sv =====
// timing: a transaction is accepted in the idle state and makes up to four dependent
// page store reads, each a read state plus a check state, before the done state and
// the output register; a full map or unmap writes its leaf in the read state with no
// check, an unused op code goes straight to done; no new one is taken until the last
// result is in the output register; reset: aresetn synchronous active low, then a pass
// zeroes all TABLE_PAGES * 512 store entries, with s_ready low until it ends
module four_level_page_table_engine_unit #(
    parameter int TABLE_PAGES = fltpe_pkg::TABLE_PAGES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  fltpe_pkg::req_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output fltpe_pkg::resp_t m_data
);

    localparam int PG_W   = $clog2(TABLE_PAGES);
    localparam int ADDR_W = PG_W + fltpe_pkg::IDX_W;
    localparam int DEPTH  = TABLE_PAGES * 512;

    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_addr;
    logic [fltpe_pkg::ENTRY_W-1:0] mem_wdata;
    logic [fltpe_pkg::ENTRY_W-1:0] mem_rdata;

    logic             res_valid;
    logic             res_ready;
    fltpe_pkg::resp_t res_data;

    logic             out_valid_reg;
    fltpe_pkg::resp_t out_data_reg;

    fltpe_walker #(
        .TABLE_PAGES (TABLE_PAGES),
        .PG_W        (PG_W),
        .ADDR_W      (ADDR_W)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req_data  (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    fltpe_ram #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .addr    (mem_addr),
        .wr_data (mem_wdata),
        .rd_data (mem_rdata)
    );

    // output register, frees the walker for the next transaction
    assign res_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_data_reg <= res_data;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
